// File: rtl/stable_priority_queue_with_id_lookup_core_macros.svh
// Assertion macros used by the priority queue controller.
`ifndef STABLE_PRIORITY_QUEUE_WITH_ID_LOOKUP_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_WITH_ID_LOOKUP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked outside reset, on the rising edge of clk.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/spq_pkg.sv
// Types and codes shared by the priority queue modules.
package spq_pkg;

  // Operation codes.
  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_POP    = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_SEARCH = 3'd3;
  localparam logic [2:0] FUNC_UPDATE = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_DUP     = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_EMPTY   = 3'd3;
  localparam logic [2:0] STAT_MISSING = 3'd4;
  localparam logic [2:0] STAT_BADPRI  = 3'd5;

  // Accepted priority range, highest first.
  localparam logic [2:0] PRI_HIGHEST = 3'd1;
  localparam logic [2:0] PRI_LOWEST  = 3'd4;

  typedef logic [4:0] occ_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  age;
    logic [2:0]  pri;
  } entry_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] entry_id;
    logic [7:0]  entry_age;
    logic [2:0]  entry_priority;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_age;
    logic [2:0]  out_priority;
    occ_t        occupancy;
  } rsp_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic   remove;
    logic   place;
    logic   pop;
    entry_t item;
  } cell_cmd_t;

endpackage

// File: rtl/stable_priority_queue_with_id_lookup_core.sv
// Top level of the stable priority queue with id lookup: controller and chain of cells.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  spq_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall  spq_pkg::rsp_t
//
// An accepted item passes through the scan, decide and done states, with a place state
// before done when it places an entry (insert, update). During the scan the match flag
// and the matched entry ripple one cell per cycle down the chain.
// Reset clears the fill count and the sequencer; cell contents are left as they are.
// A result waiting under rsp_stall does not block the next request; that request
// waits only for its own result to reach the free output register.
module stable_priority_queue_with_id_lookup_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]   count;
  spq_pkg::cell_cmd_t cmd;

  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_gt;
  logic [QUEUE_DEPTH-1:0] cell_seen;
  spq_pkg::entry_t        cell_entry [QUEUE_DEPTH];
  spq_pkg::entry_t        cell_hit   [QUEUE_DEPTH];

  spq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .found     (cell_seen[QUEUE_DEPTH-1]),
    .hit       (cell_hit[QUEUE_DEPTH-1]),
    .count     (count),
    .cmd       (cmd)
  );

  // The chain of cells; the first cell sees an always-valid neighbour in front.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic            valid_prev;
    logic            gt_prev;
    logic            seen_prev;
    spq_pkg::entry_t entry_prev;
    spq_pkg::entry_t hit_prev;
    spq_pkg::entry_t entry_next;

    assign cell_valid[g] = (CNT_W'(g) < count);

    if (g == 0) begin : g_first
      assign valid_prev = 1'b1;
      assign gt_prev    = 1'b0;
      assign seen_prev  = 1'b0;
      assign entry_prev = '0;
      assign hit_prev   = '0;
    end else begin : g_inner
      assign valid_prev = cell_valid[g-1];
      assign gt_prev    = cell_gt[g-1];
      assign seen_prev  = cell_seen[g-1];
      assign entry_prev = cell_entry[g-1];
      assign hit_prev   = cell_hit[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign entry_next = '0;
    end else begin : g_body
      assign entry_next = cell_entry[g+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .head       (g == 0),
      .valid      (cell_valid[g]),
      .valid_prev (valid_prev),
      .gt_prev    (gt_prev),
      .entry_prev (entry_prev),
      .entry_next (entry_next),
      .seen_prev  (seen_prev),
      .hit_prev   (hit_prev),
      .entry      (cell_entry[g]),
      .gt         (cell_gt[g]),
      .seen       (cell_seen[g]),
      .hit        (cell_hit[g])
    );
  end

endmodule

// File: rtl/spq_cell.sv
// One cell of the sorted chain: holds an entry, compares it and hands data on.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               head,
  input  logic               valid,
  input  logic               valid_prev,
  input  logic               gt_prev,
  input  spq_pkg::entry_t    entry_prev,
  input  spq_pkg::entry_t    entry_next,
  input  logic               seen_prev,
  input  spq_pkg::entry_t    hit_prev,
  output spq_pkg::entry_t    entry,
  output logic               gt,
  output logic               seen,
  output spq_pkg::entry_t    hit
);

  logic match;

  // A pop selects the head cell; every other operation matches on the id.
  assign match = valid && (cmd.pop ? head : (entry.id == cmd.item.id));

  // This entry ranks strictly behind the request, so a new entry goes in front of it.
  assign gt = valid && (entry.pri > cmd.item.pri);

  // The match flag and the matched entry ripple one cell further each cycle.
  always_ff @(posedge clk) begin
    seen <= seen_prev || match;
    hit  <= match ? entry : hit_prev;
  end

  // Close the gap behind a removed entry, or open one for a placed entry.
  always_ff @(posedge clk) begin
    if (cmd.remove && seen) begin
      entry <= entry_next;
    end else if (cmd.place) begin
      if (gt_prev) begin
        entry <= entry_prev;
      end else if ((gt || !valid) && valid_prev) begin
        entry <= cmd.item;
      end
    end
  end

endmodule

// File: rtl/spq_ctrl.sv
// Sequencer, fill count and result register of the priority queue.
`include "stable_priority_queue_with_id_lookup_core_macros.svh"
module spq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  spq_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output spq_pkg::rsp_t      rsp,
  input  logic               found,
  input  spq_pkg::entry_t    hit,
  output logic [CNT_W-1:0]   count,
  output spq_pkg::cell_cmd_t cmd
);

  localparam int SCAN_W = $clog2(QUEUE_DEPTH);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_PLACE  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state;
  logic [SCAN_W-1:0] scan_cnt;
  spq_pkg::req_t     req_q;
  logic [2:0]        res_status;
  spq_pkg::entry_t   res_entry;

  logic       pri_ok;
  logic       empty;
  logic       full;
  logic [2:0] status_next;
  logic       take;
  logic       rm;
  logic       pl;
  logic       rsp_free;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Decide the outcome once the match flags have settled along the chain.
  always_comb begin
    pri_ok      = req_q.entry_priority inside {[spq_pkg::PRI_HIGHEST:spq_pkg::PRI_LOWEST]};
    empty       = (count == '0);
    full        = (count == CNT_FULL);
    status_next = spq_pkg::STAT_OK;
    take        = 1'b0;
    rm          = 1'b0;
    pl          = 1'b0;
    case (req_q.func)
      spq_pkg::FUNC_INSERT: begin
        if (!pri_ok) begin
          status_next = spq_pkg::STAT_BADPRI;
        end else if (found) begin
          status_next = spq_pkg::STAT_DUP;
        end else if (full) begin
          status_next = spq_pkg::STAT_FULL;
        end else begin
          pl = 1'b1;
        end
      end
      spq_pkg::FUNC_POP: begin
        if (empty) begin
          status_next = spq_pkg::STAT_EMPTY;
        end else begin
          take = 1'b1;
          rm   = 1'b1;
        end
      end
      spq_pkg::FUNC_DELETE: begin
        if (empty) begin
          status_next = spq_pkg::STAT_EMPTY;
        end else if (!found) begin
          status_next = spq_pkg::STAT_MISSING;
        end else begin
          rm = 1'b1;
        end
      end
      spq_pkg::FUNC_SEARCH: begin
        if (!found) begin
          status_next = spq_pkg::STAT_MISSING;
        end else begin
          take = 1'b1;
        end
      end
      spq_pkg::FUNC_UPDATE: begin
        if (empty) begin
          status_next = spq_pkg::STAT_EMPTY;
        end else if (!found) begin
          status_next = spq_pkg::STAT_MISSING;
        end else if (!pri_ok) begin
          status_next = spq_pkg::STAT_BADPRI;
        end else begin
          rm = 1'b1;
          pl = 1'b1;
        end
      end
      default: begin
        status_next = spq_pkg::STAT_OK;
      end
    endcase
  end

  // Commands to the cells.
  always_comb begin
    cmd          = '0;
    cmd.remove   = (state == S_DECIDE) && rm;
    cmd.place    = (state == S_PLACE);
    cmd.pop      = (req_q.func == spq_pkg::FUNC_POP);
    cmd.item.id  = req_q.entry_id;
    cmd.item.age = req_q.entry_age;
    cmd.item.pri = req_q.entry_priority;
  end

  // Sequencer, fill count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A new result beat replaces a taken one in the same cycle.
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_cnt == SCAN_LAST) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (rm) begin
            count <= count - CNT_W'(1);
          end
          state <= pl ? S_PLACE : S_DONE;
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request, pending result and output beat.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == S_DECIDE) begin
      res_status <= status_next;
      res_entry  <= take ? hit : '0;
    end
    if (state == S_DONE && rsp_free) begin
      rsp.status       <= res_status;
      rsp.out_id       <= res_entry.id;
      rsp.out_age      <= res_entry.age;
      rsp.out_priority <= res_entry.pri;
      rsp.occupancy    <= spq_pkg::occ_t'(count);
    end
  end

  `SPQ_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && count == '0 && !rsp_valid), "reset not taken")
  `SPQ_ASSERT(a_count_bound, count <= CNT_FULL, "fill count beyond depth")
  `SPQ_ASSERT(a_remove_nonempty, cmd.remove |-> count != '0, "removal from an empty chain")
  `SPQ_ASSERT(a_place_not_full, cmd.place |-> count < CNT_FULL, "placement into a full chain")
  `SPQ_ASSERT(a_place_counts, cmd.place |=> count == $past(count) + CNT_W'(1), "placement not counted")
  `SPQ_ASSERT(a_decide_after_scan, state == S_DECIDE |-> $past(state) == S_SCAN, "decision before scan end")

endmodule

// File: dv/stable_priority_queue_with_id_lookup_core_tb.sv
// Self-checking testbench for the stable priority queue core with id lookup.
`timescale 1ns / 1ps

// Shadow copy of the queue table that predicts every result beat and checks it.
class queue_scoreboard #(int DEPTH = 16);
  spq_pkg::entry_t held[DEPTH];
  int unsigned     held_count;
  spq_pkg::rsp_t   awaited[$];
  int unsigned     err_count;
  int unsigned     result_index;

  // Position of an id in the table, or -1 when it is not held.
  function int find_id(logic [15:0] id);
    for (int i = 0; i < held_count; i++) begin
      if (held[i].id == id) return i;
    end
    return -1;
  endfunction

  // Close the gap left by a removed entry.
  function void drop_at(int pos);
    for (int i = pos; i + 1 < held_count; i++) held[i] = held[i + 1];
    held_count--;
  endfunction

  // A new entry goes behind every entry of equal or higher priority.
  function void place(spq_pkg::entry_t e);
    int pos;
    pos = 0;
    while (pos < held_count && held[pos].pri <= e.pri) pos++;
    for (int i = held_count; i > pos; i--) held[i] = held[i - 1];
    held[pos] = e;
    held_count++;
  endfunction

  // Apply one accepted request to the shadow table and queue its result.
  function void note_request(spq_pkg::req_t r);
    spq_pkg::rsp_t   want;
    spq_pkg::entry_t e;
    logic            pri_ok;
    int              pos;
    want        = '0;
    want.status = spq_pkg::STAT_OK;
    e.id        = r.entry_id;
    e.age       = r.entry_age;
    e.pri       = r.entry_priority;
    pri_ok = (r.entry_priority >= spq_pkg::PRI_HIGHEST) &&
             (r.entry_priority <= spq_pkg::PRI_LOWEST);
    pos = find_id(r.entry_id);
    case (r.func)
      spq_pkg::FUNC_INSERT: begin
        if (!pri_ok) want.status = spq_pkg::STAT_BADPRI;
        else if (pos >= 0) want.status = spq_pkg::STAT_DUP;
        else if (held_count >= DEPTH) want.status = spq_pkg::STAT_FULL;
        else place(e);
      end
      spq_pkg::FUNC_POP: begin
        if (held_count == 0) begin
          want.status = spq_pkg::STAT_EMPTY;
        end else begin
          want.out_id       = held[0].id;
          want.out_age      = held[0].age;
          want.out_priority = held[0].pri;
          drop_at(0);
        end
      end
      spq_pkg::FUNC_DELETE: begin
        if (held_count == 0) want.status = spq_pkg::STAT_EMPTY;
        else if (pos < 0) want.status = spq_pkg::STAT_MISSING;
        else drop_at(pos);
      end
      spq_pkg::FUNC_SEARCH: begin
        if (pos < 0) begin
          want.status = spq_pkg::STAT_MISSING;
        end else begin
          want.out_id       = held[pos].id;
          want.out_age      = held[pos].age;
          want.out_priority = held[pos].pri;
        end
      end
      spq_pkg::FUNC_UPDATE: begin
        if (held_count == 0) begin
          want.status = spq_pkg::STAT_EMPTY;
        end else if (pos < 0) begin
          want.status = spq_pkg::STAT_MISSING;
        end else if (!pri_ok) begin
          want.status = spq_pkg::STAT_BADPRI;
        end else begin
          drop_at(pos);
          place(e);
        end
      end
      default: ;
    endcase
    want.occupancy = spq_pkg::occ_t'(held_count);
    awaited.push_back(want);
  endfunction

  // One line per mismatch, and every mismatch is counted.
  task report(string field, int unsigned got_v, int unsigned want_v);
    err_count++;
    $display("result %0d: %s is 0x%0h, predicted 0x%0h",
             result_index, field, got_v, want_v);
  endtask

  // Compare one result beat with the oldest prediction.
  task check_response(spq_pkg::rsp_t got);
    spq_pkg::rsp_t want;
    if (awaited.size() == 0) begin
      report("status of unexpected beat", got.status, 0);
      result_index++;
      return;
    end
    want = awaited.pop_front();
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.out_id != want.out_id) report("out_id", got.out_id, want.out_id);
    if (got.out_age != want.out_age) report("out_age", got.out_age, want.out_age);
    if (got.out_priority != want.out_priority)
      report("out_priority", got.out_priority, want.out_priority);
    if (got.occupancy != want.occupancy)
      report("occupancy", got.occupancy, want.occupancy);
    result_index++;
  endtask
endclass

module stable_priority_queue_with_id_lookup_core_tb;

  localparam int          QDEPTH         = 16;
  localparam int          POOL_SIZE      = 24;
  localparam int          PHASES         = 24;
  localparam int          PHASE_ITEMS    = 60;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  // Operation codes the block treats as no operation.
  localparam logic [2:0]  FUNC_NOP_FIRST = 3'd5;
  localparam logic [2:0]  FUNC_NOP_LAST  = 3'd7;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  spq_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  spq_pkg::rsp_t rsp;

  logic          no_idle   = 1'b0;
  int unsigned   cycle_count = 0;
  logic [15:0]   id_pool[POOL_SIZE];

  queue_scoreboard #(QDEPTH) sb = new;

  stable_priority_queue_with_id_lookup_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, none during the steady stretch.
  always @(negedge clk) begin
    rsp_stall <= !no_idle && ($urandom_range(0, 99) < 26);
  end

  // Every accepted result beat is checked.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  function automatic spq_pkg::req_t mk(logic [2:0] func, logic [15:0] id,
                                       logic [7:0] age, logic [2:0] pri);
    spq_pkg::req_t r;
    r.func           = func;
    r.entry_id       = id;
    r.entry_age      = age;
    r.entry_priority = pri;
    return r;
  endfunction

  // Ids mostly hit held entries or a small pool, so lookups succeed often.
  function automatic logic [15:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50 && sb.held_count > 0)
      return sb.held[$urandom_range(0, sb.held_count - 1)].id;
    else if (roll < 85)
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  // Random request; the phase kind sets how strongly inserts are favoured.
  function automatic spq_pkg::req_t make_item(int kind);
    spq_pkg::req_t r;
    int            roll;
    int            ins_share;
    roll      = $urandom_range(0, 99);
    ins_share = (kind == 0) ? 60 : (kind == 1) ? 35 : 15;
    r.entry_id  = pick_id();
    r.entry_age = 8'($urandom);
    if ($urandom_range(0, 9) == 0) r.entry_priority = 3'($urandom_range(0, 7));
    else r.entry_priority = 3'($urandom_range(spq_pkg::PRI_HIGHEST, spq_pkg::PRI_LOWEST));
    if (roll < 2) begin
      r.func = 3'($urandom_range(FUNC_NOP_FIRST, FUNC_NOP_LAST));
    end else if (roll < 2 + ins_share) begin
      r.func = spq_pkg::FUNC_INSERT;
    end else begin
      case ($urandom_range(0, 3))
        0: r.func = spq_pkg::FUNC_POP;
        1: r.func = spq_pkg::FUNC_DELETE;
        2: r.func = spq_pkg::FUNC_SEARCH;
        default: r.func = spq_pkg::FUNC_UPDATE;
      endcase
    end
    return r;
  endfunction

  // Drive one request beat, with a random gap first, and wait for acceptance.
  task automatic send_item(spq_pkg::req_t r);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;

    // Synchronous reset, then release.
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Empty table cases.
    send_item(mk(spq_pkg::FUNC_POP, 16'h0000, 8'h00, spq_pkg::PRI_HIGHEST));
    send_item(mk(spq_pkg::FUNC_DELETE, 16'h0000, 8'h00, spq_pkg::PRI_HIGHEST));
    send_item(mk(spq_pkg::FUNC_SEARCH, 16'hFFFF, 8'hFF, spq_pkg::PRI_LOWEST));
    send_item(mk(spq_pkg::FUNC_UPDATE, 16'hFFFF, 8'hFF, spq_pkg::PRI_LOWEST));
    // Priorities outside the accepted range on insert.
    send_item(mk(spq_pkg::FUNC_INSERT, 16'h0000, 8'h00, 3'd0));
    send_item(mk(spq_pkg::FUNC_INSERT, 16'hFFFF, 8'hFF, 3'd7));
    // Extreme ids and ages; equal priorities keep arrival order.
    send_item(mk(spq_pkg::FUNC_INSERT, 16'h0000, 8'h00, spq_pkg::PRI_LOWEST));
    send_item(mk(spq_pkg::FUNC_INSERT, 16'hFFFF, 8'hFF, spq_pkg::PRI_HIGHEST));
    send_item(mk(spq_pkg::FUNC_INSERT, 16'h1234, 8'h55, spq_pkg::PRI_LOWEST));
    // Duplicate id, and bad priority taking precedence over the duplicate.
    send_item(mk(spq_pkg::FUNC_INSERT, 16'h0000, 8'h11, 3'd2));
    send_item(mk(spq_pkg::FUNC_INSERT, 16'h0000, 8'h11, 3'd5));
    // Lookups, hit and miss.
    send_item(mk(spq_pkg::FUNC_SEARCH, 16'h0000, 8'h00, 3'd0));
    send_item(mk(spq_pkg::FUNC_SEARCH, 16'h4321, 8'h00, 3'd0));
    // Update of an absent id, with a bad priority, then a good one.
    send_item(mk(spq_pkg::FUNC_UPDATE, 16'h4321, 8'h22, 3'd2));
    send_item(mk(spq_pkg::FUNC_UPDATE, 16'h0000, 8'h33, 3'd6));
    send_item(mk(spq_pkg::FUNC_UPDATE, 16'h0000, 8'h80, spq_pkg::PRI_HIGHEST));
    // Deletes, miss and hit, then drain by pops.
    send_item(mk(spq_pkg::FUNC_DELETE, 16'h9999, 8'h00, 3'd0));
    send_item(mk(spq_pkg::FUNC_DELETE, 16'h1234, 8'h00, 3'd0));
    send_item(mk(spq_pkg::FUNC_POP, 16'h0000, 8'h00, 3'd0));
    send_item(mk(spq_pkg::FUNC_POP, 16'h0000, 8'h00, 3'd0));
    // Unused operation codes.
    send_item(mk(FUNC_NOP_FIRST, 16'hA5A5, 8'h5A, 3'd3));
    send_item(mk(3'(FUNC_NOP_FIRST + 1), 16'h5A5A, 8'hA5, 3'd4));
    send_item(mk(FUNC_NOP_LAST, 16'hFFFF, 8'hFF, 3'd7));

    // Random phases cycling through filling, mixed and draining traffic.
    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle <= (ph == 10 || ph == 11);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(make_item(ph % 3));
    end
    @(negedge clk);
    req_valid <= 1'b0;
    no_idle   <= 1'b0;

    // Drain the outstanding results, then watch for stray beats.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (QDEPTH + 20) @(posedge clk);

    if (sb.err_count == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_ctrl.sv
rtl/stable_priority_queue_with_id_lookup_core.sv
dv/stable_priority_queue_with_id_lookup_core_tb.sv
